>>> hdl/dtwb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtwb_pkg;

  // sizes of the series stores and the datapath
  localparam int MAX_LEN     = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int DIST_W      = 32;
  localparam int COST_W      = SAMPLE_BITS + 1;
  localparam int FRAC_W      = 9;
  localparam int FRAC_SHIFT  = 8;
  localparam int PROD_W      = FRAC_W + LEN_W;
  localparam int BAND_W      = PROD_W - FRAC_SHIFT;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 1;

  localparam logic [DIST_W-1:0] DIST_ONES = {DIST_W{1'b1}};
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(26);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST   = 2'd0,
    CMD_SECOND  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SAT   = 2'd2,
    ST_OVF   = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_ENABLE   = 1'b0,
    CFG_BAND_FRACTION = 1'b1
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_ROW   = 6'b000100,
    S_MIN   = 6'b001000,
    S_ADD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // controls from the sequencer to the cell unit
  typedef struct packed {
    logic row_start;
    logic first_row;
    logic do_min;
    logic do_add;
    logic band_ok;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/dtw_distance_banded.sv
`timescale 1ns / 1ps
`default_nettype none

// Banded warping distance between two series of signed 16-bit samples. Append transfers
// (tuser 0 for the first series, 1 for the second) are taken one per cycle while idle; a
// sample beyond 256 is dropped and flags overflow. A compute transfer (tuser 2) blocks the
// input until its single result is loaded into the output register, then both series are
// cleared. For a full compute, one shared cell unit handles every matrix cell in two steps
// (cost and minimum, then the saturating add), and each row first fetches its first-series
// sample. Cells outside the band still pass through both steps but are forced unreachable.
// Empty or overflowed series skip the matrix and go straight to the result. Configuration
// writes are taken at any time but must only be issued while idle.

module dtw_distance_banded
  import dtwb_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // configuration
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [FRAC_W-1:0]     cfg_data,
  // input stream
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [15:0]           in_tdata,   // [15:0] sample
  input  wire  [CMD_W-1:0]      in_tuser,   // [1:0] command
  // result stream
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [31:0]           out_tdata,  // [31:0] distance
  output logic [STAT_W-1:0]     out_tuser   // [1:0] status
);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  m_len_r, m_len_nxt;
  logic [LEN_W-1:0]  n_len_r, n_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              band_en_r, band_en_nxt;
  logic [FRAC_W-1:0] band_frac_r, band_frac_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  logic [BAND_W-1:0] w_r, w_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  status_t           status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  status_t           out_stat_r, out_stat_nxt;

  // series and cost-row stores
  logic signed [SAMPLE_BITS-1:0] first_mem  [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] second_mem [MAX_LEN];
  logic        [DIST_W-1:0]      cost_mem   [MAX_LEN];
  logic signed [SAMPLE_BITS-1:0] first_q_r;
  logic signed [SAMPLE_BITS-1:0] second_q_r;
  logic        [DIST_W-1:0]      cost_q_r;

  logic              in_fire;
  logic              out_free;
  logic              wr_first;
  logic              wr_second;
  logic              rd_first;
  logic              rd_pair;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_cost;
  logic [LEN_W-1:0]  j_prev;
  logic [LEN_W-1:0]  i_prev;
  logic [LEN_W-1:0]  longer;
  logic [LEN_W-1:0]  gap;
  logic [PROD_W-1:0] prod;
  logic [BAND_W-1:0] w_base;
  logic [LEN_W-1:0]  off;
  logic [DIST_W-1:0] cell_sum;
  cell_ctl_t         cell_ctl;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_dist_r;
  assign out_tuser  = out_stat_r;

  assign j_prev = j_r - LEN_W'(1);
  assign i_prev = i_r - LEN_W'(1);

  // band half-width terms
  assign longer = (m_len_r > n_len_r) ? m_len_r : n_len_r;
  assign gap    = (m_len_r > n_len_r) ? (m_len_r - n_len_r) : (n_len_r - m_len_r);
  assign prod   = PROD_W'(band_frac_r) * PROD_W'(longer);
  assign w_base = prod[PROD_W-1:FRAC_SHIFT];
  assign off    = (i_r > j_r) ? (i_r - j_r) : (j_r - i_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    m_len_nxt     = m_len_r;
    n_len_nxt     = n_len_r;
    ovf_nxt       = ovf_r;
    band_en_nxt   = band_en_r;
    band_frac_nxt = band_frac_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    w_nxt         = w_r;
    dist_nxt      = dist_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_dist_nxt  = out_dist_r;
    out_stat_nxt  = out_stat_r;
    wr_first      = 1'b0;
    wr_second     = 1'b0;
    rd_first      = 1'b0;
    rd_pair       = 1'b0;
    rd_addr       = '0;
    wr_cost       = 1'b0;
    cell_ctl      = '0;

    // register writes
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BAND_ENABLE:   band_en_nxt   = cfg_data[0];
        CFG_BAND_FRACTION: band_frac_nxt = cfg_data;
        default: ;
      endcase
    end

    // result transfer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            CMD_FIRST: begin
              if (m_len_r < LEN_W'(MAX_LEN)) begin
                wr_first  = 1'b1;
                m_len_nxt = m_len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_SECOND: begin
              if (n_len_r < LEN_W'(MAX_LEN)) begin
                wr_second = 1'b1;
                n_len_nxt = n_len_r + LEN_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              if (ovf_r) begin
                dist_nxt   = '0;
                status_nxt = ST_OVF;
                state_nxt  = S_DONE;
              end else if (m_len_r == '0 || n_len_r == '0) begin
                dist_nxt   = '0;
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_SETUP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SETUP: begin
        w_nxt     = (w_base < BAND_W'(gap)) ? BAND_W'(gap) : w_base;
        i_nxt     = LEN_W'(1);
        state_nxt = S_ROW;
      end
      S_ROW: begin
        rd_first           = 1'b1;
        rd_pair            = 1'b1;
        rd_addr            = '0;
        cell_ctl.row_start = 1'b1;
        cell_ctl.first_row = (i_r == LEN_W'(1));
        j_nxt              = LEN_W'(1);
        state_nxt          = S_MIN;
      end
      S_MIN: begin
        cell_ctl.do_min    = 1'b1;
        cell_ctl.first_row = (i_r == LEN_W'(1));
        cell_ctl.band_ok   = !band_en_r || (BAND_W'(off) <= w_r);
        state_nxt          = S_ADD;
      end
      S_ADD: begin
        cell_ctl.do_add = 1'b1;
        wr_cost         = 1'b1;
        if (j_r < n_len_r) begin
          // fetch the next cell while this one is stored
          j_nxt     = j_r + LEN_W'(1);
          rd_pair   = 1'b1;
          rd_addr   = j_r[ADDR_W-1:0];
          state_nxt = S_MIN;
        end else if (i_r < m_len_r) begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = S_ROW;
        end else begin
          dist_nxt   = cell_sum;
          status_nxt = (cell_sum == DIST_ONES) ? ST_SAT : ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_r;
          out_stat_nxt  = status_r;
          m_len_nxt     = '0;
          n_len_nxt     = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      m_len_r     <= '0;
      n_len_r     <= '0;
      ovf_r       <= 1'b0;
      band_en_r   <= 1'b0;
      band_frac_r <= FRAC_RESET;
      i_r         <= '0;
      j_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      m_len_r     <= m_len_nxt;
      n_len_r     <= n_len_nxt;
      ovf_r       <= ovf_nxt;
      band_en_r   <= band_en_nxt;
      band_frac_r <= band_frac_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    dist_r     <= dist_nxt;
    status_r   <= status_nxt;
    out_dist_r <= out_dist_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // first series store
  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[m_len_r[ADDR_W-1:0]] <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (rd_first) begin
      first_q_r <= first_mem[i_prev[ADDR_W-1:0]];
    end
  end

  // second series store
  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[n_len_r[ADDR_W-1:0]] <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (rd_pair) begin
      second_q_r <= second_mem[rd_addr];
    end
  end

  // cost row store, entry k holds column k+1
  always_ff @(posedge clk) begin
    if (wr_cost) begin
      cost_mem[j_prev[ADDR_W-1:0]] <= cell_sum;
    end
    if (rd_pair) begin
      cost_q_r <= cost_mem[rd_addr];
    end
  end

  dtwb_cell u_cell (
    .clk   (clk),
    .ctl   (cell_ctl),
    .a_smp (first_q_r),
    .b_smp (second_q_r),
    .up_q  (cost_q_r),
    .sum_o (cell_sum)
  );

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (m_len_r <= LEN_W'(MAX_LEN)) && (n_len_r <= LEN_W'(MAX_LEN)))
    else $error("series length beyond store depth");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MIN || state_r == S_ADD) |->
      (j_r >= LEN_W'(1) && j_r <= n_len_r && i_r >= LEN_W'(1) && i_r <= m_len_r))
    else $error("cell index outside the matrix");

  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=>
      (m_len_r == '0 && n_len_r == '0 && !ovf_r && out_valid_r))
    else $error("series not cleared after result");

  a_sat_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r == ST_OK) |-> (out_dist_r != DIST_ONES))
    else $error("all-ones distance reported as ok");
`endif

endmodule

`default_nettype wire

>>> hdl/dtwb_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module dtwb_cell
  import dtwb_pkg::*;
(
  input  wire                          clk,
  input  wire cell_ctl_t               ctl,
  input  wire signed [SAMPLE_BITS-1:0] a_smp,
  input  wire signed [SAMPLE_BITS-1:0] b_smp,
  input  wire        [DIST_W-1:0]      up_q,
  output logic       [DIST_W-1:0]      sum_o
);

  logic [DIST_W-1:0] diag_r;
  logic [DIST_W-1:0] left_r;
  logic [DIST_W-1:0] min_r;
  logic [COST_W-1:0] cost_r;
  logic              band_r;

  logic [DIST_W-1:0]        up;
  logic [DIST_W-1:0]        min_ul;
  logic [DIST_W-1:0]        min3;
  logic signed [COST_W-1:0] diff;
  logic [COST_W-1:0]        cost_abs;
  logic [DIST_W:0]          sum_ext;

  // the row above does not exist on the first row
  assign up = ctl.first_row ? DIST_ONES : up_q;

  // least of the three predecessors, ties fall through
  assign min_ul = (left_r < up) ? left_r : up;
  assign min3   = (diag_r < min_ul) ? diag_r : min_ul;

  // local cost
  assign diff     = COST_W'(a_smp) - COST_W'(b_smp);
  assign cost_abs = diff[COST_W-1] ? COST_W'(-diff) : COST_W'(diff);

  // saturating accumulate, cells outside the band are unreachable
  assign sum_ext = {1'b0, min_r} + (DIST_W + 1)'(cost_r);
  always_comb begin
    if (!band_r || sum_ext[DIST_W]) begin
      sum_o = DIST_ONES;
    end else begin
      sum_o = sum_ext[DIST_W-1:0];
    end
  end

  // first step: cost and minimum, second step: add
  always_ff @(posedge clk) begin
    if (ctl.row_start) begin
      diag_r <= ctl.first_row ? '0 : DIST_ONES;
      left_r <= DIST_ONES;
    end else if (ctl.do_min) begin
      cost_r <= cost_abs;
      min_r  <= min3;
      diag_r <= up;
      band_r <= ctl.band_ok;
    end else if (ctl.do_add) begin
      left_r <= sum_o;
    end
  end

endmodule

`default_nettype wire

>>> test/dtw_distance_banded_test.sv
`timescale 1ns / 1ps

module dtw_distance_banded_test;
  import dtwb_pkg::*;

  localparam int IDLE_PCT      = 29;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES    = 32;
  localparam int PHASE_ITEMS   = 120;
  localparam int NUM_PHASES    = 6;
  localparam longint unsigned UNREACHED = 64'h0000_0000_FFFF_FFFF;
  // command code that the block ignores
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    K_ITEM,
    K_CFG,
    K_SETTLE
  } stim_kind_t;

  typedef struct {
    stim_kind_t       kind;
    logic [CMD_W-1:0] cmd;
    logic [15:0]      sample;
    cfg_idx_t         idx;
    logic [FRAC_W-1:0] value;
    bit               calm;
  } stim_t;

  typedef struct {
    logic [31:0] distance;
    status_t     status;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              cfg_valid = 1'b0;
  wire               cfg_ready;
  cfg_idx_t          cfg_index = CFG_BAND_ENABLE;
  logic [FRAC_W-1:0] cfg_data = '0;
  logic              in_tvalid = 1'b0;
  wire               in_tready;
  logic [15:0]       in_tdata = '0;
  logic [CMD_W-1:0]  in_tuser = CMD_FIRST;
  wire               out_tvalid;
  logic              out_tready = 1'b0;
  wire  [31:0]       out_tdata;
  wire  [STAT_W-1:0] out_tuser;

  dtw_distance_banded u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // pending stimulus and expected distances
  stim_t     stim_q [$];
  dist_res_t dist_due [$];

  // predictor state
  logic signed [15:0] first_pts  [0:MAX_LEN-1];
  logic signed [15:0] second_pts [0:MAX_LEN-1];
  int                 first_cnt = 0;
  int                 second_cnt = 0;
  bit                 ovf_flag = 1'b0;
  bit                 band_on = 1'b0;
  logic [FRAC_W-1:0]  band_frac = FRAC_RESET;

  // bookkeeping
  bit live = 1'b0;
  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit calm_now = 1'b0;
  bit fill_calm = 1'b0;
  int settle_cnt = 0;
  int stim_items = 0;
  int inputs_taken = 0;
  int results_checked = 0;
  int errors = 0;
  int st_count [0:3] = '{0, 0, 0, 0};

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // reset, released on a falling edge
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // backstop against a hung block
  initial begin
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // banded warping distance of the two loaded series, saturating at all ones
  function automatic logic [31:0] banded_warp_cost();
    longint unsigned row [0:MAX_LEN];
    longint unsigned diag, up, best, val;
    int m, n, longer, gap, w, off, a, b, cost, i, j;
    m = first_cnt;
    n = second_cnt;
    longer = (m > n) ? m : n;
    gap = (m > n) ? m - n : n - m;
    w = (int'(band_frac) * longer) >> FRAC_SHIFT;
    if (w < gap) w = gap;
    row[0] = 0;
    for (j = 1; j <= n; j++) row[j] = UNREACHED;
    for (i = 1; i <= m; i++) begin
      diag = row[0];
      row[0] = UNREACHED;
      for (j = 1; j <= n; j++) begin
        up = row[j];
        val = UNREACHED;
        off = (i > j) ? i - j : j - i;
        if (!band_on || off <= w) begin
          a = first_pts[i-1];
          b = second_pts[j-1];
          cost = (a > b) ? a - b : b - a;
          best = up;
          if (row[j-1] < best) best = row[j-1];
          if (diag < best) best = diag;
          val = best + longint'(cost);
          if (val > UNREACHED) val = UNREACHED;
        end
        diag = up;
        row[j] = val;
      end
    end
    return row[n][31:0];
  endfunction

  // apply one accepted input transfer to the predictor
  task automatic take_command(input logic [CMD_W-1:0] cmd, input logic [15:0] smp);
    dist_res_t r;
    case (cmd)
      CMD_FIRST: begin
        if (first_cnt < MAX_LEN) begin
          first_pts[first_cnt] = smp;
          first_cnt++;
        end else ovf_flag = 1'b1;
      end
      CMD_SECOND: begin
        if (second_cnt < MAX_LEN) begin
          second_pts[second_cnt] = smp;
          second_cnt++;
        end else ovf_flag = 1'b1;
      end
      CMD_COMPUTE: begin
        r.distance = '0;
        r.status = ST_OK;
        if (ovf_flag) r.status = ST_OVF;
        else if (first_cnt == 0 || second_cnt == 0) r.status = ST_EMPTY;
        else begin
          r.distance = banded_warp_cost();
          if (r.distance == DIST_ONES) r.status = ST_SAT;
        end
        dist_due = {dist_due, r};
        first_cnt = 0;
        second_cnt = 0;
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  // stimulus queue helpers
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [15:0] smp);
    stim_t s;
    s.kind = K_ITEM;
    s.cmd = cmd;
    s.sample = smp;
    s.idx = CFG_BAND_ENABLE;
    s.value = '0;
    s.calm = fill_calm;
    stim_q = {stim_q, s};
    if (cmd != CMD_UNUSED) stim_items++;
  endtask

  task automatic push_cfg(input cfg_idx_t idx, input logic [FRAC_W-1:0] value);
    stim_t s;
    s.kind = K_CFG;
    s.cmd = CMD_FIRST;
    s.sample = '0;
    s.idx = idx;
    s.value = value;
    s.calm = fill_calm;
    stim_q = {stim_q, s};
  endtask

  task automatic push_settle();
    stim_t s;
    s.kind = K_SETTLE;
    s.cmd = CMD_FIRST;
    s.sample = '0;
    s.idx = CFG_BAND_ENABLE;
    s.value = '0;
    s.calm = fill_calm;
    stim_q = {stim_q, s};
  endtask

  // full-range values half the time, with extremes and values near zero
  function automatic logic [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r < 5) return 16'($urandom_range(0, 31) - 16);
    return 16'($urandom);
  endfunction

  // load m and n samples in random interleaving, with an occasional ignored command, then compute
  task automatic add_set(input int m, input int n);
    int a, b;
    a = m;
    b = n;
    while (a + b > 0) begin
      if ($urandom_range(0, 99) < 3) push_item(CMD_UNUSED, 16'($urandom));
      if (b == 0 || (a > 0 && $urandom_range(0, 1) == 1)) begin
        push_item(CMD_FIRST, pick_sample());
        a--;
      end else begin
        push_item(CMD_SECOND, pick_sample());
        b--;
      end
    end
    push_item(CMD_COMPUTE, 16'($urandom));
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_stim
    stim_t nxt;
    if (live) begin
      out_tready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
      if ((in_tvalid && !in_taken) || (cfg_valid && !cfg_taken)) begin
        // transfer still pending, hold it
      end else if (stim_q.size() == 0) begin
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        nxt = stim_q[0];
        calm_now <= nxt.calm;
        if (nxt.kind == K_SETTLE) begin
          // wait for every result, then let the block go quiet
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
          if (dist_due.size() != 0) settle_cnt <= 0;
          else if (settle_cnt < SETTLE_CYCLES) settle_cnt <= settle_cnt + 1;
          else begin
            settle_cnt <= 0;
            stim_q.delete(0);
          end
        end else if (!nxt.calm && $urandom_range(0, 99) < IDLE_PCT) begin
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (nxt.kind == K_CFG) begin
          in_tvalid <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_index <= nxt.idx;
          cfg_data <= nxt.value;
          stim_q.delete(0);
        end else begin
          cfg_valid <= 1'b0;
          in_tvalid <= 1'b1;
          in_tdata <= nxt.sample;
          in_tuser <= nxt.cmd;
          stim_q.delete(0);
        end
      end
    end
  end

  // monitor: sample every handshake on the rising edge
  always @(posedge clk) begin : watch_ports
    dist_res_t want;
    live <= rst_n;
    in_taken <= rst_n && in_tvalid && in_tready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      // result transfer against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (dist_due.size() == 0) begin
          report_mismatch("result with none pending", out_tdata, 32'd0);
        end else begin
          want = dist_due.pop_front();
          results_checked++;
          st_count[want.status]++;
          if (out_tdata !== want.distance)
            report_mismatch("distance", out_tdata, want.distance);
          if (out_tuser !== want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BAND_ENABLE) band_on = cfg_data[0];
        else band_frac = cfg_data;
      end
      // input transfer
      if (in_tvalid && in_tready) begin
        inputs_taken++;
        take_command(in_tuser, in_tdata);
      end
    end
  end

  // stimulus plan and end of run
  initial begin : plan
    bit                ph_en   [0:NUM_PHASES-1];
    logic [FRAC_W-1:0] ph_frac [0:NUM_PHASES-1];
    int p, mark, roll, k;

    // directed: empty compute, ignored command, extremes, ties
    push_item(CMD_COMPUTE, 16'h0000);
    push_item(CMD_UNUSED, 16'hFFFF);
    push_item(CMD_FIRST, 16'h7FFF);
    push_item(CMD_SECOND, 16'h8000);
    push_item(CMD_COMPUTE, 16'hFFFF);
    push_item(CMD_FIRST, 16'h8000);
    push_item(CMD_FIRST, 16'h7FFF);
    push_item(CMD_SECOND, 16'h0000);
    push_item(CMD_COMPUTE, 16'h5555);
    push_item(CMD_FIRST, 16'h1234);
    push_item(CMD_COMPUTE, 16'hAAAA);
    push_item(CMD_SECOND, 16'hFFFF);
    push_item(CMD_COMPUTE, 16'h0000);
    push_item(CMD_FIRST, 16'd5);
    push_item(CMD_FIRST, 16'd5);
    push_item(CMD_SECOND, 16'd5);
    push_item(CMD_FIRST, 16'd5);
    push_item(CMD_SECOND, 16'd5);
    push_item(CMD_COMPUTE, 16'h0000);

    // band settings per phase, extremes included
    ph_en[0] = 1'b1;  ph_frac[0] = '0;
    ph_en[1] = 1'b1;  ph_frac[1] = FRAC_RESET;
    ph_en[2] = 1'b1;  ph_frac[2] = 9'd256;
    ph_en[3] = 1'b1;  ph_frac[3] = 9'd511;
    ph_en[4] = 1'b1;  ph_frac[4] = 9'($urandom_range(1, 255));
    ph_en[5] = 1'b0;  ph_frac[5] = 9'd511;

    for (p = 0; p < NUM_PHASES; p++) begin
      fill_calm = (p == 3);
      push_settle();
      push_cfg(CFG_BAND_ENABLE, 9'(ph_en[p]));
      push_cfg(CFG_BAND_FRACTION, ph_frac[p]);
      // one full-size matrix, and overflow on each series
      if (p == 1) add_set(MAX_LEN, MAX_LEN);
      if (p == 2) add_set(MAX_LEN + $urandom_range(1, 4), $urandom_range(1, 8));
      if (p == 4) add_set($urandom_range(1, 8), MAX_LEN + $urandom_range(1, 3));
      mark = stim_items;
      while (stim_items - mark < PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < 6) add_set($urandom_range(1, 40), $urandom_range(1, 40));
        else if (roll < 84) add_set($urandom_range(1, 12), $urandom_range(1, 12));
        else if (roll < 87) add_set(0, $urandom_range(0, 6));
        else if (roll < 90) add_set($urandom_range(1, 6), 0);
        else if (roll < 95) begin
          // loose commands of any kind, then a compute
          k = $urandom_range(1, 5);
          repeat (k) push_item(2'($urandom_range(0, 3)), 16'($urandom));
          push_item(CMD_COMPUTE, 16'($urandom));
        end else push_settle();
      end
    end
    fill_calm = 1'b0;

    wait (stim_q.size() == 0);
    @(posedge clk);
    while (in_tvalid || cfg_valid || dist_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    $display("run covered %0d input transfers and %0d results over %0d band settings",
             inputs_taken, results_checked, NUM_PHASES + 1);
    $display("status counts: ok %0d, empty %0d, saturated %0d, overflow %0d",
             st_count[ST_OK], st_count[ST_EMPTY], st_count[ST_SAT], st_count[ST_OVF]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
